[src/pofs_pkg.sv]
// ----------------------------------------------------------------------------
// pofs_pkg
// Shared types and constants for the PCM output fade stage.
// ----------------------------------------------------------------------------
package pofs_pkg;

  localparam int DEF_COUNTER_WIDTH = 48;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] UNITY_GAIN = 16'h8000;
  localparam logic [9:0]  FADE_MS    = 10'd500;
  localparam logic [9:0]  MS_PER_S   = 10'd1000;
  localparam logic [7:0]  PCM8_MID   = 8'h80;
  localparam logic [6:0]  PCM8_MAX   = 7'h7F;
  localparam logic [14:0] PCM16_MAX  = 15'h7FFF;

  // dt * 32768 / 500 == (dt << 13) / 125; /125 as multiply by ceil(2^29 / 125)
  localparam logic [22:0] RECIP_125   = 23'd4294968;
  localparam int          RECIP_SHIFT = 29;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_BLOCK  = 2'd1,
    ACT_SHUT   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MODE_UP   = 3'd0,
    MODE_RUN  = 3'd1,
    MODE_SHUT = 3'd2,
    MODE_DOWN = 3'd3,
    MODE_FIN  = 3'd4
  } fade_mode_t;

  typedef enum logic [1:0] {
    REG_VOLUME = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_VBITS  = 2'd2,
    REG_RATE   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_24 = 2'd2,
    WIDTH_32 = 2'd3
  } width_code_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_RAMP
  } front_state_t;

  // Sample request handed from front to back.
  typedef struct packed {
    logic [31:0] sample;
    logic [15:0] gain;
    logic        finished;
  } job_t;

endpackage

[src/pofs_front.sv]
// ----------------------------------------------------------------------------
// pofs_front
// Accepts requests, runs the fade state machine and block-start timing
// (bit-serial divider), and forwards sample jobs with their gain.
// ----------------------------------------------------------------------------
module pofs_front import pofs_pkg::*; #(
  parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] sample_value,
  input  logic [9:0]  frame_count,
  input  logic [18:0] rate_hz,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_full
);

  localparam int NUM_W = 50;  // span (< 2^40) * 1000 fits in 50 bits
  localparam int CNT_W = $clog2(NUM_W + 1);

  fade_mode_t          mode, mode_next;
  front_state_t        state, state_next;
  logic [COUNTER_WIDTH-1:0] counter, mark;
  logic [15:0]         gain;
  logic [9:0]          frames;
  logic [NUM_W-1:0]    quo;
  logic [19:0]         rem;
  logic [CNT_W-1:0]    cnt;
  logic                accept;
  logic [COUNTER_WIDTH-1:0] span;
  logic [63:0]         span64;
  logic                big, done_now;
  logic [NUM_W-1:0]    num;
  logic [28:0]         limit;
  logic [59:0]         span_ms;
  logic [19:0]         rem_sh;
  logic [22:0]         ramp_num;
  logic [45:0]         ramp_prod;
  logic [15:0]         ramp_val;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != FS_IDLE) || job_full;

  assign span = (mode == MODE_DOWN) ? (counter - mark) : counter;
  assign span64  = 64'(span);
  assign big     = |span64[63:40];
  assign span_ms = 60'(span64[39:0]) * 60'(MS_PER_S);
  assign limit   = 29'(rate_hz) * 29'(FADE_MS);
  assign done_now = big || (span_ms >= 60'(limit));
  assign num = span_ms[NUM_W-1:0];

  assign rem_sh = {rem[18:0], num[CNT_W'(NUM_W - 1) - cnt]};
  assign ramp_num  = {quo[9:0], 13'd0};
  assign ramp_prod = 46'(ramp_num) * 46'(RECIP_125);
  assign ramp_val  = 16'(ramp_prod >> RECIP_SHIFT);

  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: if (accept && action == ACT_BLOCK &&
                   (mode == MODE_UP || mode == MODE_DOWN) && !done_now)
                 state_next = FS_DIV;
      FS_DIV:  if (cnt == CNT_W'(NUM_W - 1)) state_next = FS_RAMP;
      FS_RAMP: state_next = FS_IDLE;
      default: state_next = FS_IDLE;
    endcase
  end

  always_comb begin
    mode_next = mode;
    if (state == FS_IDLE && accept) begin
      case (action)
        ACT_SHUT:  if (mode == MODE_RUN) mode_next = MODE_SHUT;
        ACT_BLOCK: begin
          if (mode == MODE_SHUT) mode_next = MODE_DOWN;
          else if (mode == MODE_UP && done_now) mode_next = MODE_RUN;
          else if (mode == MODE_DOWN && done_now) mode_next = MODE_FIN;
        end
        default: mode_next = mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FS_IDLE;
      mode    <= MODE_UP;
      counter <= '0;
      mark    <= '0;
      gain    <= '0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      if (state == FS_IDLE && accept && action == ACT_BLOCK) begin
        frames <= frame_count;
        rem    <= '0;
        quo    <= '0;
        cnt    <= '0;
        case (mode)
          MODE_SHUT: begin
            mark <= counter;
            gain <= UNITY_GAIN;
          end
          MODE_UP:   if (done_now) gain <= UNITY_GAIN;
          MODE_DOWN: if (done_now) gain <= '0;
          MODE_RUN:  gain <= UNITY_GAIN;
          default:   gain <= '0;
        endcase
        if (!((mode == MODE_UP || mode == MODE_DOWN) && !done_now))
          counter <= counter + COUNTER_WIDTH'(frame_count);
      end
      if (state == FS_DIV) begin
        cnt <= cnt + 1'b1;
        if (rem_sh >= {1'b0, rate_hz}) begin
          rem <= rem_sh - {1'b0, rate_hz};
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
      end
      if (state == FS_RAMP) begin
        gain    <= (mode == MODE_DOWN) ? UNITY_GAIN - ramp_val : ramp_val;
        counter <= counter + COUNTER_WIDTH'(frames);
      end
    end
  end

  assign job_valid    = accept && action == ACT_SAMPLE;
  assign job.sample   = sample_value;
  assign job.gain     = gain;
  assign job.finished = (mode >= MODE_FIN);

endmodule

[src/pofs_queue.sv]
// ----------------------------------------------------------------------------
// pofs_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module pofs_queue import pofs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  output logic rd_valid,
  output job_t rd_data,
  input  logic rd_en
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  job_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   fill;

  assign full     = (fill == (AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

[src/pofs_back.sv]
// ----------------------------------------------------------------------------
// pofs_back
// Sample path: gain and volume multiply, clamp, PCM conversion, output reg.
// ----------------------------------------------------------------------------
module pofs_back import pofs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  input  logic [15:0] master_volume,
  input  logic [1:0]  sample_width_code,
  input  logic [5:0]  valid_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pcm_word,
  output logic [2:0]  byte_count,
  output logic        fade_finished
);

  // stage 1: gain * volume, sign/magnitude
  logic        s1_valid, s1_neg, s1_fin;
  logic [31:0] s1_gv, s1_mag;
  // stage 2: magnitude product clamped to Q1.30
  logic        s2_valid, s2_neg, s2_fin;
  logic [30:0] s2_mag;
  // stage 3: scale by full-scale value
  logic        s3_valid, s3_neg, s3_fin;
  logic [61:0] s3_prod;
  logic [5:0]  s3_vb;
  logic [1:0]  s3_code;
  logic        adv;

  logic [63:0] prod1;
  logic [30:0] mag_c;
  logic [5:0]  vb, cont;
  logic [31:0] m;
  logic [31:0] r, rr, word;
  logic        exact;

  assign adv      = !out_valid || !out_stall;
  assign job_take = job_valid && adv;

  assign prod1 = 64'(s1_mag) * 64'(s1_gv);
  assign mag_c = (prod1[63:22] > 42'(32'h4000_0000)) ? 31'h4000_0000 : prod1[52:22];

  always_comb begin
    cont = (sample_width_code == WIDTH_24) ? 6'd24 : 6'd32;
    vb = valid_bits;
    if (vb < 6'd8) vb = 6'd8;
    if (vb > cont) vb = cont;
    case (sample_width_code)
      WIDTH_8:  m = 32'(PCM8_MAX);
      WIDTH_16: m = 32'(PCM16_MAX);
      default:  m = (32'd1 << (vb - 6'd1)) - 32'd1;
    endcase
  end

  always_comb begin
    r = s3_prod[61:30];
    exact = (s3_prod[29:0] == '0);
    rr = (s3_neg && !exact) ? r + 32'd1 : r;
    case (s3_code)
      WIDTH_8:  word = 32'(s3_neg ? PCM8_MID - rr[7:0] : PCM8_MID + r[7:0]);
      WIDTH_16: word = 32'((s3_neg ? 16'(0 - r) : r[15:0]));
      WIDTH_24: word = 32'(24'((s3_neg ? 32'(0 - r) : r) << (6'd24 - s3_vb)));
      default:  word = (s3_neg ? 32'(0 - r) : r) << (6'd32 - s3_vb);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= job_take;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg <= job.sample[31];
      s1_mag <= job.sample[31] ? 32'(0 - job.sample) : job.sample;
      s1_gv  <= 32'(job.gain) * 32'(master_volume);
      s1_fin <= job.finished;
      s2_mag <= mag_c;
      s2_neg <= s1_neg && (mag_c != '0);
      s2_fin <= s1_fin;
      s3_prod <= 62'(s2_mag) * 62'(m);
      s3_neg  <= s2_neg;
      s3_fin  <= s2_fin;
      s3_vb   <= vb;
      s3_code <= sample_width_code;
      pcm_word      <= word;
      byte_count    <= 3'(s3_code) + 3'd1;
      fade_finished <= s3_fin;
    end
  end

endmodule

[src/pcm_output_fade_stage.sv]
// ----------------------------------------------------------------------------
// pcm_output_fade_stage
// Audio output stage: fade gain, master volume, clamp and PCM conversion.
// ----------------------------------------------------------------------------
// Sample requests leave through a four-stage multiply/convert pipeline. A
// block-start request that lands mid-fade holds the input, once it is taken,
// through a 50-step bit-serial divide that turns the frame span into
// milliseconds and then a ramp step that sets the new gain; other block starts
// and shutdowns do not hold it. A full queue also holds the input.
// Samples queued behind a block start keep the gain in force when they came.
module pcm_output_fade_stage import pofs_pkg::*; #(
  parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] sample_value,
  input  logic [9:0]  frame_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pcm_word,
  output logic [2:0]  byte_count,
  output logic        fade_finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [15:0] master_volume;
  logic [1:0]  sample_width_code;
  logic [5:0]  valid_bits;
  logic [18:0] rate_hz;
  logic        q_wr, q_full, q_valid, q_take;
  job_t        q_in, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume     <= 16'd16384;
      sample_width_code <= 2'd1;
      valid_bits        <= 6'd16;
      rate_hz           <= 19'd48000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VOLUME: master_volume     <= cfg_data[15:0];
        REG_WIDTH:  sample_width_code <= cfg_data[1:0];
        REG_VBITS:  valid_bits        <= cfg_data[5:0];
        REG_RATE:   rate_hz           <= cfg_data[18:0];
        default:    master_volume     <= master_volume;
      endcase
    end
  end

  pofs_front #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .action, .sample_value, .frame_count,
    .rate_hz, .job_valid(q_wr), .job(q_in), .job_full(q_full)
  );

  pofs_queue u_queue (
    .clk, .rst, .wr_en(q_wr), .wr_data(q_in), .full(q_full),
    .rd_valid(q_valid), .rd_data(q_out), .rd_en(q_take)
  );

  pofs_back u_back (
    .clk, .rst, .job_valid(q_valid), .job(q_out), .job_take(q_take),
    .master_volume, .sample_width_code, .valid_bits,
    .out_valid, .out_stall, .pcm_word, .byte_count, .fade_finished
  );

endmodule
